@@ rtl/assert_macros.svh @@
// Assertion macros shared by the line render scheduler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a same-cycle implication on clk, idle during reset.
`define VLRS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vlrs assertion failed");

// Check a next-cycle implication on clk, idle during reset.
`define VLRS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vlrs assertion failed");

`else

`define VLRS_ASSERT_IMP(label, ante, cons)
`define VLRS_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ rtl/vlrs_pkg.sv @@
// Types and constants shared by the line render scheduler modules.
package vlrs_pkg;

	localparam int IDX_W  = 11;
	localparam int LINE_W = 10;
	localparam int FULL_W = 12;
	localparam int DIV_W  = 5;
	localparam int NUM_W  = 12;

	// Register indexes on the APB port
	localparam logic [2:0] REG_TOTAL_LINES      = 3'd0;
	localparam logic [2:0] REG_ODD_FIELD_START  = 3'd1;
	localparam logic [2:0] REG_EVEN_FIELD_START = 3'd2;
	localparam logic [2:0] REG_ACTIVE_LINES     = 3'd3;
	localparam logic [2:0] REG_LINE_DIVIDER     = 3'd4;
	localparam logic [2:0] REG_FRAME_ROWS       = 3'd5;
	localparam logic [2:0] REG_INTERLACED_MODE  = 3'd6;
	localparam logic [2:0] REG_TWO_BUFFERS      = 3'd7;

	typedef struct packed {
		logic [10:0] total_lines;
		logic [9:0]  odd_field_start;
		logic [9:0]  even_field_start;
		logic [10:0] active_lines;
		logic [4:0]  line_divider;
		logic [10:0] frame_rows;
		logic        interlaced_mode;
		logic        two_buffers_per_line;
	} vlrs_cfg_t;

	// Word handed from cell to cell along the divider chain
	typedef struct packed {
		logic [LINE_W-1:0] cur_line;
		logic              skip;
		logic              active;
		logic              vsync;
		logic [LINE_W-1:0] buf_line;
		logic [NUM_W-1:0]  num;
		logic [DIV_W-1:0]  rem;
		logic [NUM_W-1:0]  quo;
	} vlrs_word_t;

endpackage

@@ rtl/video_line_render_scheduler_top.sv @@
// Video line render scheduler: front end, divider cell chain and result register.
//
// One finished-buffer index is taken per clock and one result leaves per clock
// when result_ready stays high. An accepted index passes through fifteen register
// stages on its way to the result port: two front-end stages (render-ahead wrap,
// field decode), twelve divider cells, one per bit of the 12-bit row dividend,
// and the result register, where the row is checked against frame_rows. Each
// stage stalls only when it is full and the stage after it cannot take its word,
// so bubbles are squeezed out under backpressure. The user must write configuration
// over the APB port only while no index is in flight; the block does not enforce it.
`include "assert_macros.svh"
module video_line_render_scheduler_top
	import vlrs_pkg::*;
#(
	parameter int LINES_AHEAD = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [IDX_W-1:0]  finished_buffer_index,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [LINE_W-1:0] current_line,
	output logic              render_now,
	output logic [LINE_W-1:0] buffer_line,
	output logic [LINE_W-1:0] frame_row,
	output logic              vsync_pulse
);

	vlrs_cfg_t         cfg;
	logic [DIV_W-1:0]  div;
	logic [NUM_W:0]    chain_valid;
	logic [NUM_W:0]    chain_ready;
	vlrs_word_t        chain_word [NUM_W+1];

	vlrs_word_t        last;
	logic              render;
	logic              load_res;
	logic [LINE_W-1:0] row_lo;
	logic              result_valid_q;
	logic              res_ready;
	logic [LINE_W-1:0] current_line_q;
	logic              render_now_q;
	logic [LINE_W-1:0] buffer_line_q;
	logic [LINE_W-1:0] frame_row_q;
	logic              vsync_pulse_q;

	vlrs_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Treat a zero divider as one
	assign div = (cfg.line_divider == '0) ? DIV_W'(1) : cfg.line_divider;

	vlrs_front #(
		.LINES_AHEAD (LINES_AHEAD)
	) u_front (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg                   (cfg),
		.item_valid            (item_valid),
		.item_ready            (item_ready),
		.finished_buffer_index (finished_buffer_index),
		.out_valid             (chain_valid[0]),
		.out_ready             (chain_ready[0]),
		.out_word              (chain_word[0])
	);

	// Chain of divider cells, most significant quotient bit first
	for (genvar gi = 0; gi < NUM_W; gi++) begin : g_cell
		vlrs_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.div       (div),
			.in_valid  (chain_valid[gi]),
			.in_ready  (chain_ready[gi]),
			.in_word   (chain_word[gi]),
			.out_valid (chain_valid[gi+1]),
			.out_ready (chain_ready[gi+1]),
			.out_word  (chain_word[gi+1])
		);
	end

	// Range-check the row and hold the result word
	assign last       = chain_word[NUM_W];
	assign row_lo     = last.quo[LINE_W-1:0];
	assign render     = last.active && (last.quo < {1'b0, cfg.frame_rows});
	assign res_ready  = !result_valid_q || result_ready;
	assign load_res   = chain_valid[NUM_W] && res_ready;
	assign chain_ready[NUM_W] = res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_ready) begin
			result_valid_q <= chain_valid[NUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			current_line_q <= last.cur_line;
			render_now_q   <= render;
			buffer_line_q  <= last.buf_line;
			frame_row_q    <= render ? row_lo : '0;
			vsync_pulse_q  <= last.vsync;
		end
	end

	assign result_valid = result_valid_q;
	assign current_line = current_line_q;
	assign render_now   = render_now_q;
	assign buffer_line  = buffer_line_q;
	assign frame_row    = frame_row_q;
	assign vsync_pulse  = vsync_pulse_q;

	`VLRS_ASSERT_NXT(a_render_in_range, load_res && render, render_now_q && (frame_row_q == $past(row_lo)))
	`VLRS_ASSERT_IMP(a_skip_quiet, chain_valid[NUM_W] && last.skip, !last.active && !last.vsync && (last.buf_line == '0))

endmodule

@@ rtl/vlrs_apb.sv @@
// APB configuration registers of the line render scheduler.
module vlrs_apb
	import vlrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output vlrs_cfg_t   cfg
);

	vlrs_cfg_t cfg_q;
	logic      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Write a register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_lines          <= 11'd525;
			cfg_q.odd_field_start      <= '0;
			cfg_q.even_field_start     <= '0;
			cfg_q.active_lines         <= '0;
			cfg_q.line_divider         <= 5'd1;
			cfg_q.frame_rows           <= '0;
			cfg_q.interlaced_mode      <= 1'b0;
			cfg_q.two_buffers_per_line <= 1'b0;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_TOTAL_LINES:      cfg_q.total_lines          <= pwdata[10:0];
				REG_ODD_FIELD_START:  cfg_q.odd_field_start      <= pwdata[9:0];
				REG_EVEN_FIELD_START: cfg_q.even_field_start     <= pwdata[9:0];
				REG_ACTIVE_LINES:     cfg_q.active_lines         <= pwdata[10:0];
				REG_LINE_DIVIDER:     cfg_q.line_divider         <= pwdata[4:0];
				REG_FRAME_ROWS:       cfg_q.frame_rows           <= pwdata[10:0];
				REG_INTERLACED_MODE:  cfg_q.interlaced_mode      <= pwdata[0];
				REG_TWO_BUFFERS:      cfg_q.two_buffers_per_line <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (paddr[4:2])
			REG_TOTAL_LINES:      prdata = {21'd0, cfg_q.total_lines};
			REG_ODD_FIELD_START:  prdata = {22'd0, cfg_q.odd_field_start};
			REG_EVEN_FIELD_START: prdata = {22'd0, cfg_q.even_field_start};
			REG_ACTIVE_LINES:     prdata = {21'd0, cfg_q.active_lines};
			REG_LINE_DIVIDER:     prdata = {27'd0, cfg_q.line_divider};
			REG_FRAME_ROWS:       prdata = {21'd0, cfg_q.frame_rows};
			REG_INTERLACED_MODE:  prdata = {31'd0, cfg_q.interlaced_mode};
			REG_TWO_BUFFERS:      prdata = {31'd0, cfg_q.two_buffers_per_line};
			default:              prdata = '0;
		endcase
	end

endmodule

@@ rtl/vlrs_front.sv @@
// Line mapping front end: render-ahead wrap, then field decode into a dividend.
module vlrs_front
	import vlrs_pkg::*;
#(
	parameter int LINES_AHEAD = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vlrs_cfg_t        cfg,
	input  logic             item_valid,
	output logic             item_ready,
	input  logic [IDX_W-1:0] finished_buffer_index,
	output logic             out_valid,
	input  logic             out_ready,
	output vlrs_word_t       out_word
);

	logic              valid_s1;
	logic              ready_s1;
	logic [LINE_W-1:0] cur_s1;
	logic              skip_s1;
	logic [FULL_W-1:0] line_s1;

	logic              valid_s2;
	logic              ready_s2;
	vlrs_word_t        word_s2;

	logic [IDX_W-1:0]  cur;
	logic [FULL_W-1:0] sum;
	logic [FULL_W-1:0] total_x;
	logic [FULL_W-1:0] line;

	logic [FULL_W-1:0] odd_x;
	logic [FULL_W-1:0] even_x;
	logic [FULL_W-1:0] odd_end;
	logic [FULL_W-1:0] even_end;
	logic [FULL_W-1:0] odd_off;
	logic [FULL_W-1:0] even_off;
	logic              in_odd;
	logic              in_even;
	logic              active;
	logic [NUM_W-1:0]  num;

	assign ready_s2   = !valid_s2 || out_ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign item_ready = ready_s1;
	assign out_valid  = valid_s2;
	assign out_word   = word_s2;

	// Halve the index in two-buffer mode and wrap the render-ahead line once
	always_comb begin
		cur     = cfg.two_buffers_per_line ? {1'b0, finished_buffer_index[IDX_W-1:1]}
		                                   : finished_buffer_index;
		sum     = {1'b0, cur} + FULL_W'(LINES_AHEAD);
		total_x = {1'b0, cfg.total_lines};
		line    = (sum >= total_x) ? sum - total_x : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && ready_s1) begin
			cur_s1  <= cur[LINE_W-1:0];
			skip_s1 <= cfg.two_buffers_per_line & finished_buffer_index[0];
			line_s1 <= line;
		end
	end

	// Decide the field and build the dividend
	always_comb begin
		odd_x    = {2'b00, cfg.odd_field_start};
		even_x   = {2'b00, cfg.even_field_start};
		odd_end  = odd_x + {1'b0, cfg.active_lines};
		even_end = even_x + {1'b0, cfg.active_lines};
		odd_off  = line_s1 - odd_x;
		even_off = line_s1 - even_x;
		in_odd   = (line_s1 >= odd_x) && (line_s1 < odd_end);
		in_even  = (line_s1 >= even_x) && (line_s1 < even_end);
		active   = 1'b0;
		num      = '0;
		if (!cfg.interlaced_mode) begin
			if (line_s1 >= odd_x) begin
				active = 1'b1;
				num    = odd_off;
			end
		end else if (in_odd) begin
			active = 1'b1;
			num    = {odd_off[NUM_W-2:0], 1'b0};
		end else if (in_even) begin
			active = 1'b1;
			num    = {even_off[NUM_W-2:0], 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Zero the render fields on the second half of a line
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			word_s2.cur_line <= cur_s1;
			word_s2.skip     <= skip_s1;
			word_s2.active   <= active & ~skip_s1;
			word_s2.vsync    <= ~skip_s1 & (line_s1 == '0);
			word_s2.buf_line <= skip_s1 ? '0 : line_s1[LINE_W-1:0];
			word_s2.num      <= num;
			word_s2.rem      <= '0;
			word_s2.quo      <= '0;
		end
	end

endmodule

@@ rtl/vlrs_div_cell.sv @@
// One restoring-division cell: settles one quotient bit and passes the word on.
`include "assert_macros.svh"
module vlrs_div_cell
	import vlrs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIV_W-1:0] div,
	input  logic             in_valid,
	output logic             in_ready,
	input  vlrs_word_t       in_word,
	output logic             out_valid,
	input  logic             out_ready,
	output vlrs_word_t       out_word
);

	logic             valid_q;
	vlrs_word_t       word_q;
	logic [DIV_W:0]   trial;
	logic             qbit;
	vlrs_word_t       next_word;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	// Shift in the next dividend bit and subtract the divisor if it fits
	always_comb begin
		next_word = in_word;
		trial     = {in_word.rem, in_word.num[NUM_W-1]};
		qbit      = (trial >= {1'b0, div});
		next_word.rem = qbit ? DIV_W'(trial - {1'b0, div}) : trial[DIV_W-1:0];
		next_word.num = {in_word.num[NUM_W-2:0], 1'b0};
		next_word.quo = {in_word.quo[NUM_W-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= next_word;
		end
	end

	`VLRS_ASSERT_IMP(a_rem_below_div, valid_q && (div != '0), word_q.rem < div)
	`VLRS_ASSERT_NXT(a_load_fills, in_valid && in_ready, valid_q)

endmodule
